/* hdl/pfscr_pkg.sv */
// shared widths and codes for the playfield scroll address block
`timescale 1ns / 1ps

package pfscr_pkg;

	// fixed field widths
	localparam int MODE_W     = 2;
	localparam int TIDX_W     = 9;
	localparam int DATA_W     = 16;
	localparam int SCREEN_W   = 8;
	localparam int SRC_W      = 10;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// visible screen size used for the flipped origin
	localparam logic [15:0] VISIBLE_SIZE = 16'd256;

	// item modes
	localparam logic [MODE_W-1:0] MODE_ROW_WR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COL_WR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PIXEL  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PEN    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_SHIFT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_SHIFT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLES   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PEN_RULE  = 4'd7;

	// playfield shapes
	localparam logic [1:0] SHAPE_1024X256 = 2'd0;
	localparam logic [1:0] SHAPE_512X512  = 2'd1;
	localparam logic [1:0] SHAPE_256X1024 = 2'd2;

	// pen rules
	localparam logic [1:0] PEN_NORMAL = 2'd0;
	localparam logic [1:0] PEN_ALL    = 2'd1;
	localparam logic [1:0] PEN_FRONT  = 2'd2;

endpackage

/* hdl/pfscr_if.sv */
// channel interfaces: input items, results and register writes
`timescale 1ns / 1ps

interface pfscr_item_if;
	logic                            valid;
	logic                            ready;
	logic [pfscr_pkg::MODE_W-1:0]    mode;
	logic [pfscr_pkg::TIDX_W-1:0]    table_index;
	logic [pfscr_pkg::DATA_W-1:0]    data_value;
	logic [pfscr_pkg::SCREEN_W-1:0]  screen_x;
	logic [pfscr_pkg::SCREEN_W-1:0]  screen_y;

	modport source (output valid, mode, table_index, data_value, screen_x, screen_y,
		input ready);
	modport sink (input valid, mode, table_index, data_value, screen_x, screen_y,
		output ready);
endinterface

interface pfscr_result_if;
	logic                         valid;
	logic                         ready;
	logic [pfscr_pkg::SRC_W-1:0]  source_x;
	logic [pfscr_pkg::SRC_W-1:0]  source_y;
	logic                         write_enable;

	modport source (output valid, source_x, source_y, write_enable, input ready);
	modport sink (input valid, source_x, source_y, write_enable, output ready);
endinterface

interface pfscr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pfscr_pkg::CFG_IDX_W-1:0]   index;
	logic [pfscr_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/playfield_row_col_scroll_fetch_top.sv */
// playfield row/column scroll address generator with pen test
`timescale 1ns / 1ps

// usage:
//   item   - input beats: row table write, column table write, pixel address or pen test
//   result - one beat per pixel address or pen test, none for table writes
//   cfg    - register writes (scroll, shifts, flip, enables, shape, pen rule),
//            always ready, only to be written while the block is idle
// path: an accepted item beat passes the input stage, the row table read and the column
//   table read, then the result register drives its result beat
// throughput: one item per cycle while result.ready keeps up; the row table read and
//   the column table read each take one registered memory port in their own stage
// stalls: a stage advances whenever the one after it is empty or moving, so
//   item beats keep being taken into bubbles while a result waits on result.ready
// reset: control and config registers clear at once, then a clearing pass writes zero
//   into both tables, one entry a cycle, across max(ROW_TABLE_DEPTH, COL_TABLE_DEPTH)
//   entries (512 by default); item.ready stays low during the pass, cfg writes are taken
// keep table depths powers of two (unchecked); indexes wrap mod depth, col writes mod 64
module playfield_row_col_scroll_fetch_top #(
	parameter int ROW_TABLE_DEPTH = 512,
	parameter int COL_TABLE_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	pfscr_item_if.sink     item,
	pfscr_result_if.source result,
	pfscr_cfg_if.sink      cfg
);

	localparam int RW     = $clog2(ROW_TABLE_DEPTH);
	localparam int CW     = $clog2(COL_TABLE_DEPTH);
	localparam int CLR_N  = (ROW_TABLE_DEPTH > COL_TABLE_DEPTH) ? ROW_TABLE_DEPTH
		: COL_TABLE_DEPTH;
	localparam int CLR_W  = $clog2(CLR_N);
	localparam int SRC_W_L = pfscr_pkg::SRC_W - 1;
	localparam logic [RW-1:0]    ROW_MAX  = RW'(ROW_TABLE_DEPTH - 1);
	localparam logic [CW-1:0]    COL_MAX  = CW'(COL_TABLE_DEPTH - 1);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

	// configuration registers
	logic [15:0] scroll_x_q;
	logic [15:0] scroll_y_q;
	logic [3:0]  row_shift_q;
	logic [3:0]  col_shift_q;
	logic        flip_q;
	logic [1:0]  enables_q;
	logic [1:0]  shape_q;
	logic [1:0]  pen_rule_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_x_q  <= '0;
			scroll_y_q  <= '0;
			row_shift_q <= '0;
			col_shift_q <= '0;
			flip_q      <= 1'b0;
			enables_q   <= '0;
			shape_q     <= '0;
			pen_rule_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pfscr_pkg::REG_SCROLL_X:  scroll_x_q  <= cfg.data;
				pfscr_pkg::REG_SCROLL_Y:  scroll_y_q  <= cfg.data;
				pfscr_pkg::REG_ROW_SHIFT: row_shift_q <= cfg.data[3:0];
				pfscr_pkg::REG_COL_SHIFT: col_shift_q <= cfg.data[3:0];
				pfscr_pkg::REG_FLIP:      flip_q      <= cfg.data[0];
				pfscr_pkg::REG_ENABLES:   enables_q   <= cfg.data[1:0];
				pfscr_pkg::REG_SHAPE:     shape_q     <= cfg.data[1:0];
				pfscr_pkg::REG_PEN_RULE:  pen_rule_q  <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// playfield dimensions; shape code three falls back to 1024x256
	logic [15:0] pf_w;
	logic [15:0] pf_h;

	always_comb begin
		case (shape_q)
			pfscr_pkg::SHAPE_512X512: begin
				pf_w = 16'd512;
				pf_h = 16'd512;
			end
			pfscr_pkg::SHAPE_256X1024: begin
				pf_w = 16'd256;
				pf_h = 16'd1024;
			end
			default: begin
				pf_w = 16'd1024;
				pf_h = 16'd256;
			end
		endcase
	end

	// clearing pass after reset
	logic             clr_busy_q;
	logic [CLR_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// pipeline flow control
	logic vld_s1, vld_s2, vld_s3;
	logic res_vld_q;
	logic free1, free2, free3;
	logic ld2, ld3, en3, acc;
	logic is_res_s3;

	logic [pfscr_pkg::MODE_W-1:0]   mode_s1, mode_s2, mode_s3;
	logic [pfscr_pkg::TIDX_W-1:0]   tidx_s1, tidx_s2;
	logic [pfscr_pkg::DATA_W-1:0]   data_s1, data_s2, data_s3;
	logic [pfscr_pkg::SCREEN_W-1:0] scr_x_s1, scr_x_s2;
	logic [pfscr_pkg::SCREEN_W-1:0] scr_y_s1;
	logic [15:0]                    line_s2, line_s3;
	logic [15:0]                    sx_s3;
	logic [15:0]                    row_rd_s2;
	logic [15:0]                    col_rd_s3;

	assign is_res_s3 = (mode_s3 == pfscr_pkg::MODE_PIXEL) || (mode_s3 == pfscr_pkg::MODE_PEN);
	assign en3   = vld_s3 && (!is_res_s3 || !res_vld_q || result.ready);
	assign free3 = !vld_s3 || en3;
	assign ld3   = vld_s2 && free3;
	assign free2 = !vld_s2 || ld3;
	assign ld2   = vld_s1 && free2;
	assign free1 = !vld_s1 || ld2;

	assign item.ready = free1 && !clr_busy_q;
	assign acc        = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (free1) begin
				vld_s1 <= acc;
			end
			if (free2) begin
				vld_s2 <= ld2;
			end
			if (free3) begin
				vld_s3 <= ld3;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1  <= item.mode;
			tidx_s1  <= item.table_index;
			data_s1  <= item.data_value;
			scr_x_s1 <= item.screen_x;
			scr_y_s1 <= item.screen_y;
		end
	end

	// source line: base y (mirrored when flipped) plus screen y
	logic [15:0]   base_y;
	logic [15:0]   line_c;
	logic [RW-1:0] row_idx;

	assign base_y  = flip_q ? (pf_h - pfscr_pkg::VISIBLE_SIZE - scroll_y_q) : scroll_y_q;
	assign line_c  = base_y + {8'h00, scr_y_s1};
	assign row_idx = RW'(line_c >> row_shift_q) & (ROW_MAX >> row_shift_q);

	// row scroll table, one write and one registered read per cycle
	logic [15:0] row_mem [ROW_TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			row_mem[clr_cnt_q[RW-1:0]] <= '0;
		end else if (ld2 && mode_s1 == pfscr_pkg::MODE_ROW_WR) begin
			row_mem[RW'(tidx_s1)] <= data_s1;
		end
		if (ld2) begin
			row_rd_s2 <= row_mem[row_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			mode_s2  <= mode_s1;
			tidx_s2  <= tidx_s1;
			data_s2  <= data_s1;
			scr_x_s2 <= scr_x_s1;
			line_s2  <= line_c;
		end
	end

	// stage 2: source column from base x, row offset, flip and screen x
	logic [15:0]   bx_raw;
	logic [15:0]   bx;
	logic [15:0]   sx_c;
	logic [4:0]    col_shamt;
	logic [CW-1:0] col_idx;

	assign bx_raw    = scroll_x_q + (enables_q[0] ? row_rd_s2 : 16'h0000);
	assign bx        = flip_q ? (pf_w - pfscr_pkg::VISIBLE_SIZE - bx_raw) : bx_raw;
	assign sx_c      = bx + {8'h00, scr_x_s2};
	assign col_shamt = {1'b0, col_shift_q} + 5'd3;
	assign col_idx   = CW'(sx_c >> col_shamt) & (COL_MAX >> col_shift_q);

	// column scroll table
	logic [15:0] col_mem [COL_TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			col_mem[clr_cnt_q[CW-1:0]] <= '0;
		end else if (ld3 && mode_s2 == pfscr_pkg::MODE_COL_WR) begin
			col_mem[CW'(tidx_s2[5:0])] <= data_s2;
		end
		if (ld3) begin
			col_rd_s3 <= col_mem[col_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			mode_s3 <= mode_s2;
			data_s3 <= data_s2;
			line_s3 <= line_s2;
			sx_s3   <= sx_c;
		end
	end

	// stage 3: column offset, shape masks and pen test
	logic [15:0]                 sy_c;
	logic [pfscr_pkg::SRC_W-1:0] src_x_c;
	logic [pfscr_pkg::SRC_W-1:0] src_y_c;
	logic                        pen_we;

	assign sy_c    = line_s3 + (enables_q[1] ? col_rd_s3 : 16'h0000);
	assign src_x_c = sx_s3[SRC_W_L:0] & (pf_w[SRC_W_L:0] - 1'b1);
	assign src_y_c = sy_c[SRC_W_L:0] & (pf_h[SRC_W_L:0] - 1'b1);

	always_comb begin
		case (pen_rule_q)
			pfscr_pkg::PEN_ALL:   pen_we = 1'b1;
			pfscr_pkg::PEN_FRONT: pen_we = data_s3[7] & data_s3[3];
			default:              pen_we = |data_s3[3:0];
		endcase
	end

	// result register
	logic [pfscr_pkg::SRC_W-1:0] src_x_q;
	logic [pfscr_pkg::SRC_W-1:0] src_y_q;
	logic                        we_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en3 && is_res_s3) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && is_res_s3) begin
			if (mode_s3 == pfscr_pkg::MODE_PIXEL) begin
				src_x_q <= src_x_c;
				src_y_q <= src_y_c;
				we_q    <= 1'b0;
			end else begin
				src_x_q <= '0;
				src_y_q <= '0;
				we_q    <= pen_we;
			end
		end
	end

	assign result.valid        = res_vld_q;
	assign result.source_x     = src_x_q;
	assign result.source_y     = src_y_q;
	assign result.write_enable = we_q;

endmodule
